@@ rtl/swmc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swmc_pkg: shared definitions for the sliding-window median and cost block
// Widths, window depth and the control word that drives every sorting cell.
// ============================================================================

package swmc_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = IDX_W + 1;
    localparam int WIN_W      = 7;
    localparam int SAMPLE_W   = 32;
    localparam int COST_W     = 38;
    localparam int SUM_LANES  = 4;
    localparam int LANE_SH    = $clog2(SUM_LANES);
    localparam int STEP_W     = $clog2(WINDOW_MAX / SUM_LANES) + 1;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_DIFF,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [SAMPLE_W-1:0]   key;
        logic [SAMPLE_W-1:0]   med;
    } cell_ctrl_t;

endpackage

@@ rtl/swmc_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// swmc_cell: one slot of the sorted sample chain
// Holds one sample and its deviation; inserts, removes and shifts with its
// neighbors so the chain stays sorted by value, ties oldest first.
// ============================================================================

module swmc_cell
    import swmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] left_value,
    input  logic                left_valid,
    input  logic                left_open,
    input  logic [SAMPLE_W-1:0] right_value,
    input  logic                right_valid,
    input  logic [SAMPLE_W-1:0] far_diff,
    output logic [SAMPLE_W-1:0] value,
    output logic                valid,
    output logic                open,
    output logic [SAMPLE_W-1:0] diff
);

    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic                valid_reg, valid_next;
    logic [SAMPLE_W-1:0] diff_reg, diff_next;
    logic                ge;

    // A slot is open to the inserted key when it is empty or holds a larger
    // value, so equal values stay ahead of the newcomer.
    assign open = !valid_reg || (value_reg > ctrl.key);
    assign ge   = valid_reg && (value_reg >= ctrl.key);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        diff_next  = diff_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            CELL_INSERT:
            begin
                if (open && left_open)
                begin
                    value_next = left_value;
                    valid_next = left_valid;
                end
                else if (open)
                begin
                    value_next = ctrl.key;
                    valid_next = 1'b1;
                end
            end
            CELL_REMOVE:
            begin
                // The first slot at or above the key is the oldest copy.
                if (ge)
                begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
            CELL_DIFF:
            begin
                if (!valid_reg)
                    diff_next = '0;
                else if (value_reg >= ctrl.med)
                    diff_next = value_reg - ctrl.med;
                else
                    diff_next = ctrl.med - value_reg;
            end
            CELL_SHIFT:
            begin
                diff_next = far_diff;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        diff_reg  <= diff_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign diff  = diff_reg;

endmodule

@@ rtl/sliding_window_median_cost.sv @@
`timescale 1ns / 1ps
// Each beat that fills the window steps through PREP, OLD_READ, REMOVE, INSERT,
// MED_SEL, DIFF, SUM and FINISH to its result; REMOVE runs only on a full window.
// The input stalls until the sequencer is back in IDLE, so no new beat is taken
// before the last is done; SUM adds the deviations of four cells per cycle.
// After a window_size write the next beat first reloads up to K-1 samples from the
// arrival ring via REBUILD/REBUILD_INS. Reset empties the window, no sweep.
// ============================================================================
// sliding_window_median_cost: streaming lower median and absolute deviation
// A sorted chain of cells holds the window; the median is picked by rank and
// the cost is summed from per-cell deviations.
// ============================================================================

module sliding_window_median_cost
    import swmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [WIN_W-1:0]    window_size,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                start_of_stream,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SAMPLE_W-1:0] median,
    output logic [COST_W-1:0]   cost
);

    // The sequencer walks each beat through these steps. REBUILD and
    // REBUILD_INS alternate to reload the chain from the arrival ring
    // after the window length changes.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_REBUILD,
        ST_REBUILD_INS,
        ST_OLD_READ,
        ST_REMOVE,
        ST_INSERT,
        ST_MED_SEL,
        ST_DIFF,
        ST_SUM,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic                rebuild_reg, rebuild_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    reload_reg, reload_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                sos_reg, sos_next;
    logic [SAMPLE_W-1:0] med_reg, med_next;
    logic [COST_W-1:0]   acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] median_reg, median_next;
    logic [COST_W-1:0]   cost_reg, cost_next;

    // Arrival ring, one write and one registered read per cycle.
    logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                ring_we;

    // Chain wiring.
    cell_ctrl_t          ctrl;
    logic [SAMPLE_W-1:0] cell_value [WINDOW_MAX];
    logic                cell_valid [WINDOW_MAX];
    logic                cell_open  [WINDOW_MAX];
    logic [SAMPLE_W-1:0] cell_diff  [WINDOW_MAX];

    logic [CNT_W-1:0]    k_eff;
    logic [CNT_W-1:0]    k_less;
    logic [IDX_W-1:0]    mid;
    logic [CNT_W-1:0]    lanes_up;
    logic [SAMPLE_W-1:0] med_sel;
    logic [COST_W-1:0]   lane_sum;
    logic [CNT_W-1:0]    fill_base;
    logic [CNT_W-1:0]    fill_inc;
    logic                in_take;
    logic                out_take;

    // A zero length acts as one; anything above the chain depth saturates.
    always_comb
    begin
        if (window_reg == '0)
            k_eff = CNT_W'(1);
        else if (window_reg > WIN_W'(WINDOW_MAX))
            k_eff = CNT_W'(WINDOW_MAX);
        else
            k_eff = CNT_W'(window_reg);
    end

    assign k_less   = k_eff - CNT_W'(1);
    assign mid      = IDX_W'(k_less >> 1);
    assign lanes_up = k_eff + CNT_W'(SUM_LANES - 1);

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // The lower median sits at a fixed rank of the sorted chain.
    always_comb
    begin
        med_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (IDX_W'(i) == mid)
                med_sel = med_sel | cell_value[i];
        end
    end

    always_comb
    begin
        lane_sum = acc_reg;
        for (int i = 0; i < SUM_LANES; i++)
            lane_sum = lane_sum + COST_W'(cell_diff[i]);
    end

    assign fill_base = sos_reg ? '0 : fill_reg;
    assign fill_inc  = (fill_reg == CNT_W'(WINDOW_MAX)) ? fill_reg : fill_reg + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        rebuild_next   = rebuild_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        reload_next    = reload_reg;
        steps_next     = steps_reg;
        sample_next    = sample_reg;
        sos_next       = sos_reg;
        med_next       = med_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        cost_next      = cost_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.key       = rd_data_reg;
        ctrl.med       = med_reg;
        rd_addr        = head_reg - reload_reg[IDX_W-1:0];
        ring_we        = 1'b0;

        if (out_take)
            out_valid_next = 1'b0;

        if (cfg_write_en)
        begin
            window_next  = window_size;
            rebuild_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    sample_next = sample;
                    sos_next    = start_of_stream;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // A new stream or a new length restarts the chain; the
                // older samples still inside the window are reloaded.
                if (sos_reg || rebuild_reg)
                begin
                    ctrl.op      = CELL_CLEAR;
                    count_next   = '0;
                    rebuild_next = 1'b0;
                    fill_next    = fill_base;
                    reload_next  = (fill_base < k_less) ? fill_base : k_less;
                    if (sos_reg)
                        head_next = '0;
                    state_next = ST_REBUILD;
                end
                else
                begin
                    state_next = ST_OLD_READ;
                end
            end
            ST_REBUILD:
            begin
                if (reload_reg == '0)
                begin
                    state_next = ST_OLD_READ;
                end
                else
                begin
                    reload_next = reload_reg - CNT_W'(1);
                    state_next  = ST_REBUILD_INS;
                end
            end
            ST_REBUILD_INS:
            begin
                ctrl.op    = CELL_INSERT;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_REBUILD;
            end
            ST_OLD_READ:
            begin
                // With a full window the oldest sample leaves first.
                rd_addr = head_reg - k_eff[IDX_W-1:0];
                if (count_reg == k_eff)
                    state_next = ST_REMOVE;
                else
                    state_next = ST_INSERT;
            end
            ST_REMOVE:
            begin
                ctrl.op    = CELL_REMOVE;
                count_next = count_reg - CNT_W'(1);
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                ctrl.op    = CELL_INSERT;
                ctrl.key   = sample_reg;
                count_next = count_reg + CNT_W'(1);
                ring_we    = 1'b1;
                head_next  = head_reg + IDX_W'(1);
                fill_next  = fill_inc;
                if (fill_inc >= k_eff)
                    state_next = ST_MED_SEL;
                else
                    state_next = ST_IDLE;
            end
            ST_MED_SEL:
            begin
                med_next   = med_sel;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                ctrl.op    = CELL_DIFF;
                acc_next   = '0;
                steps_next = STEP_W'(lanes_up >> LANE_SH);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // Deviations slide down the chain, a group of lanes per cycle.
                ctrl.op    = CELL_SHIFT;
                acc_next   = lane_sum;
                steps_next = steps_reg - STEP_W'(1);
                if (steps_reg == STEP_W'(1))
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    median_next    = med_reg;
                    cost_next      = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            rebuild_reg   <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            reload_reg    <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            rebuild_reg   <= rebuild_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            reload_reg    <= reload_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        sos_reg    <= sos_next;
        med_reg    <= med_next;
        acc_reg    <= acc_next;
        median_reg <= median_next;
        cost_reg   <= cost_next;
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[head_reg] <= sample_reg;
        rd_data_reg <= ring_mem[rd_addr];
    end

    // The sorted chain. Slot zero holds the smallest value.
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_W-1:0] lv;
        logic                lvld;
        logic                lopen;
        logic [SAMPLE_W-1:0] rv;
        logic                rvld;
        logic [SAMPLE_W-1:0] fd;

        if (i == 0)
        begin : g_first
            assign lv    = '0;
            assign lvld  = 1'b0;
            assign lopen = 1'b0;
        end
        else
        begin : g_inner
            assign lv    = cell_value[i-1];
            assign lvld  = cell_valid[i-1];
            assign lopen = cell_open[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_last
            assign rv   = '0;
            assign rvld = 1'b0;
        end
        else
        begin : g_mid
            assign rv   = cell_value[i+1];
            assign rvld = cell_valid[i+1];
        end

        if (i + SUM_LANES < WINDOW_MAX)
        begin : g_far
            assign fd = cell_diff[i+SUM_LANES];
        end
        else
        begin : g_end
            assign fd = '0;
        end

        swmc_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_value  (lv),
            .left_valid  (lvld),
            .left_open   (lopen),
            .right_value (rv),
            .right_valid (rvld),
            .far_diff    (fd),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .open        (cell_open[i]),
            .diff        (cell_diff[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign cost      = cost_reg;

endmodule

@@ dv/tb_sliding_window_median_cost.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_sliding_window_median_cost: self-checking bench for the median/cost block
// A table of directed beats, a full-window run, then random streams drive the block.
// A behavioral predictor keeps the last samples in arrival order and computes
// the lower median and the absolute-deviation cost once the window is full.
// Results are checked in order against a queue of expected medians and costs.
// ============================================================================

module tb_sliding_window_median_cost;
    import swmc_pkg::*;

    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_BEATS = 1064;
    localparam int   DRAIN_CYCLES = 60;
    localparam logic [WIN_W-1:0] WIN_FULL = 7'd64;

    // One row of the directed table. When has_check is set, the predicted result
    // of this beat must also match the hand-written median and cost.
    typedef struct {
        logic [WIN_W-1:0]    win;
        logic                set_win;
        logic [SAMPLE_W-1:0] value;
        logic                sos;
        logic                has_check;
        logic [SAMPLE_W-1:0] exp_med;
        logic [COST_W-1:0]   exp_cost;
    } dir_row_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] med;
        logic [COST_W-1:0]   cst;
    } median_cost_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [WIN_W-1:0]    window_size;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample;
    logic                start_of_stream;
    logic                out_valid;
    logic                out_stall;
    logic [SAMPLE_W-1:0] median;
    logic [COST_W-1:0]   cost;

    // Predictor state: arrival ring, fill count and the window register.
    logic [SAMPLE_W-1:0] hist_ring [WINDOW_MAX];
    int                  hist_head;
    int                  hist_fill;
    logic [WIN_W-1:0]    win_reg;

    median_cost_t        pending_results [$];
    int                  error_count;
    int                  cycle_count = 0;
    bit                  hold_off_req;
    bit                  quiet_in;
    bit                  quiet_out;

    sliding_window_median_cost i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .window_size     (window_size),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .start_of_stream (start_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .median          (median),
        .cost            (cost)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Advances the predictor by one accepted beat. Returns 1 with the result
    // when the window is full.
    function automatic bit predict_window(input logic [SAMPLE_W-1:0] value, input logic sos,
                                          output median_cost_t res);
        int                  k;
        int                  n;
        int                  j;
        logic [SAMPLE_W-1:0] vals [WINDOW_MAX];
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] m;
        logic [COST_W:0]     acc;
        if (sos)
        begin
            hist_fill = 0;
            hist_head = 0;
        end
        hist_ring[hist_head] = value;
        hist_head = (hist_head + 1) % WINDOW_MAX;
        if (hist_fill < WINDOW_MAX)
            hist_fill++;
        k = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg));
        res = '0;
        if (hist_fill < k)
            return 1'b0;
        // Insertion sort of the last k samples; only the median value matters,
        // so the order among equal values has no effect on the result.
        n = 0;
        for (int a = k - 1; a >= 0; a--)
        begin
            v = hist_ring[(hist_head + WINDOW_MAX - 1 - a) % WINDOW_MAX];
            j = n;
            while (j > 0 && vals[j-1] > v)
            begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
            n++;
        end
        m   = vals[(k - 1) / 2];
        acc = '0;
        for (int i = 0; i < k; i++)
        begin
            acc = acc + ((vals[i] >= m) ? (vals[i] - m) : (m - vals[i]));
            if (acc > {1'b0, {COST_W{1'b1}}})
                acc = {1'b0, {COST_W{1'b1}}};
        end
        res.med = m;
        res.cst = acc[COST_W-1:0];
        return 1'b1;
    endfunction

    // Idle-time register write; the predictor follows it.
    task automatic write_window(input logic [WIN_W-1:0] w);
        cfg_write_en <= 1'b1;
        window_size  <= w;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        win_reg = w;
    endtask

    // Waits until every expected result has come, then a few idle cycles in
    // case the last beat was still being worked on without a result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Offers one beat and holds it until the block accepts it. The valid
    // line stays high after acceptance so the next beat can follow at once.
    task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic sos,
                             input logic has_check, input median_cost_t want);
        median_cost_t res;
        bit           got;
        bit           idle;
        idle = !quiet_in && ($urandom_range(99) < 23);
        if (idle)
            in_valid <= 1'b0;
        while (idle)
        begin
            @(posedge clk);
            idle = ($urandom_range(99) < 23);
        end
        in_valid        <= 1'b1;
        sample          <= value;
        start_of_stream <= sos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        got = predict_window(value, sos, res);
        if (got)
        begin
            if (has_check && res != want)
            begin
                $display("%0t table row disagrees with predictor: expected %h/%h predicted %h/%h",
                         $realtime, want.med, want.cst, res.med, res.cst);
                error_count++;
            end
            pending_results.push_back(res);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample(input int mode);
        case (mode)
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFFF - $urandom_range(15);
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall, with a quiet stretch and one long hold-off
    // that lets the block fill up and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_off_req)
            out_stall <= 1'b1;
        else
            out_stall <= !quiet_out && ($urandom_range(99) < 23);
    end

    initial
    begin
        hold_off_req = 1'b0;
        wait (rst_n);
        repeat (3000)
            @(posedge clk);
        hold_off_req = 1'b1;
        repeat (400)
            @(posedge clk);
        hold_off_req = 1'b0;
    end

    // Checker: a result beat is taken when out_valid is high and out_stall low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result beat: actual %h/%h", $realtime, median, cost);
                error_count++;
            end
            else
            begin
                if (median !== pending_results[0].med)
                begin
                    $display("%0t median mismatch: expected %h actual %h",
                             $realtime, pending_results[0].med, median);
                    error_count++;
                end
                if (cost !== pending_results[0].cst)
                begin
                    $display("%0t cost mismatch: expected %h actual %h",
                             $realtime, pending_results[0].cst, cost);
                    error_count++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        dir_row_t     rows [$];
        median_cost_t want;
        int           win_pick;
        int           run_len;
        int           mode;
        int           sent;

        error_count     = 0;
        quiet_in        = 1'b0;
        quiet_out       = 1'b0;
        hist_head       = 0;
        hist_fill       = 0;
        win_reg         = WINDOW_RESET;
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        window_size     = WINDOW_RESET;
        in_valid        = 1'b0;
        sample          = '0;
        start_of_stream = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: window of three after reset, extreme values, a window of one,
        // a zero window, windows of two and four, and an oversized window.
        //         win    set   value          sos   chk   median         cost
        rows.push_back('{7'd3, 1'b0, 32'd5,         1'b1, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd3, 1'b0, 32'd1,         1'b0, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd3, 1'b0, 32'd9,         1'b0, 1'b1, 32'd5, 38'd8});
        rows.push_back('{7'd3, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'd9, 38'hFFFF_FFFE});
        rows.push_back('{7'd3, 1'b0, 32'h0,         1'b0, 1'b1, 32'd9, 38'hFFFF_FFFF});
        rows.push_back('{7'd3, 1'b0, 32'h7,         1'b1, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 38'd0});
        rows.push_back('{7'd1, 1'b0, 32'h0,         1'b1, 1'b1, 32'h0, 38'd0});
        rows.push_back('{7'd0, 1'b1, 32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678, 38'd0});
        rows.push_back('{7'd2, 1'b1, 32'h0,         1'b1, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd2, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 38'hFFFF_FFFF});
        rows.push_back('{7'd2, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 38'd0});
        rows.push_back('{7'd4, 1'b1, 32'd3,         1'b0, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd4, 1'b0, 32'd3,         1'b0, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd127, 1'b1, 32'hAAAA_5555, 1'b0, 1'b0, 32'd0, 38'd0});
        rows.push_back('{7'd127, 1'b0, 32'h5555_AAAA, 1'b0, 1'b0, 32'd0, 38'd0});

        foreach (rows[r])
        begin
            if (rows[r].set_win)
            begin
                wait_idle();
                write_window(rows[r].win);
            end
            want.med = rows[r].exp_med;
            want.cst = rows[r].exp_cost;
            send_beat(rows[r].value, rows[r].sos, rows[r].has_check, want);
        end

        // A full window of 64 alternating extremes gives the largest cost.
        wait_idle();
        write_window(WIN_FULL);
        for (int i = 0; i < 70; i++)
            send_beat((i % 2) ? 32'hFFFF_FFFF : 32'h0, i == 0, 1'b0, want);

        // Random streams: each starts with a clear, runs for 10 to 60 beats, and
        // mostly uses windows of one to nine; the rest use larger, zero or oversized ones.
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            wait_idle();
            win_pick = $urandom_range(99);
            if (win_pick < 70)
                write_window(WIN_W'($urandom_range(1, 9)));
            else if (win_pick < 85)
                write_window(WIN_W'($urandom_range(10, 64)));
            else if (win_pick < 92)
                write_window($urandom_range(1) ? 7'd0 : 7'd64);
            else
                write_window(WIN_W'($urandom_range(65, 127)));
            quiet_in  = ($urandom_range(9) == 0);
            quiet_out = quiet_in;
            mode      = $urandom_range(4);
            run_len   = $urandom_range(10, 60);
            for (int i = 0; i < run_len; i++)
            begin
                // Occasional clears in mid-stream are the noise.
                send_beat(rand_sample(mode), (i == 0) || ($urandom_range(49) == 0),
                          1'b0, want);
                sent++;
            end
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;

        wait_idle();
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
